// ===== hdl/srt_pkg.sv =====
package srt_pkg;

  // default store depth
  localparam int unsigned CAPACITY_DEF = 256;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W  = 9;

  // stored keys have the sign bit flipped so unsigned order is signed order
  localparam logic [VALUE_W-1:0] SIGN_BIAS = 32'h8000_0000;

  localparam logic [RANK_W-1:0] RANK_MAX  = 9'd255;
  localparam logic [RANK_W-1:0] RANK_NONE = 9'h1FF;
  localparam logic [RANK_W-1:0] RANK_ZERO = 9'd0;

  typedef enum logic {
    CMD_TRACK = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_TRACKED = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_FOUND   = 2'd2,
    STATUS_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/srt_in_if.sv =====
interface srt_in_if import srt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  cmd_t                       command;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== hdl/srt_out_if.sv =====
interface srt_out_if import srt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  status_t                   status;
  logic signed [RANK_W-1:0]  rank;

  modport source (output valid, output status, output rank, input ready);
  modport sink   (input valid, input status, input rank, output ready);
endinterface

// ===== hdl/srt_ram.sv =====
module srt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/stream_rank_tracker.sv =====
// stream_rank_tracker
// keeps a bounded store of signed 32-bit values and answers rank queries
// req channel (sink): one word holds command and value; command track appends
//   value to the store, command query asks for the rank of value
// rsp channel (source): exactly one word per req word, in order; status tracked,
//   store full (value dropped), query found or query not found; rank is the
//   count of stored values at most value, minus one, saturated at 255, -1 when
//   the value is not stored, 0 for track words
// path: a track word goes through the emit state into the output register; a
//   query first scans the store, which is read one entry per cycle through
//   the single ram read port into one shared compare unit
// throughput: one req word at a time; req.ready is high only while idle, so the
//   next word follows as soon as the current one has been moved to the output
//   register
// reset: clears the fill count and the control state, the store holds nothing
//   valid afterwards; no clearing pass is needed since only filled entries are read
// stall: the rsp word sits in its output register until rsp.ready; the block
//   can take one more req word meanwhile and holds its result until the
//   output register frees up
module stream_rank_tracker import srt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  srt_in_if.sink    req,
  srt_out_if.source rsp
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W = CNT_W + RANK_W;

  state_t state, state_next;

  // fill count of the store
  logic [CNT_W-1:0] count, count_next;

  // current word
  logic [VALUE_W-1:0] key, key_next;

  // scan bookkeeping
  logic [CNT_W-1:0] issued, issued_next;
  logic             rd_pend, rd_pend_next;
  logic [CNT_W-1:0] at_most, at_most_next;
  logic             found, found_next;

  // result waiting for the output register
  status_t          res_status, res_status_next;
  logic [RANK_W-1:0] res_rank, res_rank_next;

  // output register
  logic              rsp_valid, rsp_valid_next;
  status_t           rsp_status, rsp_status_next;
  logic [RANK_W-1:0] rsp_rank, rsp_rank_next;

  // ram ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // shared compare unit
  logic cmp_le, cmp_eq;

  // rank saturation
  logic [CNT_W-1:0] rank_raw;
  logic [EXT_W-1:0] rank_ext;
  logic [RANK_W-1:0] rank_sat;

  logic [VALUE_W-1:0] in_key;
  logic               accept;
  logic               out_free;

  srt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmp_le = (ram_rdata <= key);
  assign cmp_eq = (ram_rdata == key);

  assign rank_raw = at_most_next - CNT_W'(1);
  assign rank_ext = EXT_W'(rank_raw);
  assign rank_sat = (rank_ext > EXT_W'(RANK_MAX)) ? RANK_MAX : rank_ext[RANK_W-1:0];

  assign in_key   = req.value ^ SIGN_BIAS;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.rank   = rsp_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_pend   <= rd_pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key        <= key_next;
    issued     <= issued_next;
    at_most    <= at_most_next;
    found      <= found_next;
    res_status <= res_status_next;
    res_rank   <= res_rank_next;
    rsp_status <= rsp_status_next;
    rsp_rank   <= rsp_rank_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    key_next        = key;
    issued_next     = issued;
    rd_pend_next    = rd_pend;
    at_most_next    = at_most;
    found_next      = found;
    res_status_next = res_status;
    res_rank_next   = res_rank;
    rsp_valid_next  = rsp_valid;
    rsp_status_next = rsp_status;
    rsp_rank_next   = rsp_rank;

    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = in_key;
    ram_raddr = issued[IDX_W-1:0];

    // receiver takes the current word
    if (rsp_valid && rsp.ready) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          key_next = in_key;
          if (req.command == CMD_TRACK) begin
            res_rank_next = RANK_ZERO;
            if (count == CNT_W'(CAPACITY)) begin
              res_status_next = STATUS_FULL;
            end else begin
              ram_we          = 1'b1;
              count_next      = count + CNT_W'(1);
              res_status_next = STATUS_TRACKED;
            end
            state_next = ST_EMIT;
          end else if (count == '0) begin
            res_status_next = STATUS_MISSING;
            res_rank_next   = RANK_NONE;
            state_next      = ST_EMIT;
          end else begin
            // first read goes out now
            ram_raddr    = '0;
            issued_next  = CNT_W'(1);
            rd_pend_next = 1'b1;
            at_most_next = '0;
            found_next   = 1'b0;
            state_next   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (rd_pend) begin
          if (cmp_le) begin
            at_most_next = at_most + CNT_W'(1);
          end
          if (cmp_eq) begin
            found_next = 1'b1;
          end
          // keep one read in flight per cycle
          if (issued < count) begin
            issued_next  = issued + CNT_W'(1);
            rd_pend_next = 1'b1;
          end else begin
            rd_pend_next = 1'b0;
          end
        end else begin
          if (found) begin
            res_status_next = STATUS_FOUND;
            res_rank_next   = rank_sat;
          end else begin
            res_status_next = STATUS_MISSING;
            res_rank_next   = RANK_NONE;
          end
          state_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = res_status;
          rsp_rank_next   = res_rank;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
